### sv/fosct_pkg.sv
package fosct_pkg;

   // field widths of the request and response
   localparam int DB_W    = 32;
   localparam int ROLE_W  = 32;
   localparam int KIND_W  = 3;
   localparam int SKIND_W = 2;
   localparam int SLOT_W  = 7;
   localparam int CFG_W   = 7;

   // slot index answered when nothing was found or claimed
   localparam logic [SLOT_W-1:0] NO_SLOT = '1;
   // slots_in_use after reset
   localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_DONE
   } fosct_state_type;

   // one table entry as stored in the memory
   typedef struct packed {
      logic [DB_W-1:0]    db;
      logic [ROLE_W-1:0]  role;
      logic [SKIND_W-1:0] kind;
   } fosct_entry_type;

   // one response item
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              claimed;
      logic              full;
      logic              first;
   } fosct_result_type;

   // control toward the memo
   typedef struct packed {
      logic               load_key;
      logic               update;
      logic [SKIND_W-1:0] sel;
      logic [SLOT_W-1:0]  slot;
   } fosct_memo_cmd_type;

   // status back from the memo
   typedef struct packed {
      logic              key_same;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } fosct_memo_stat_type;

endpackage

### sv/fosct_mem.sv
module fosct_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  fosct_pkg::fosct_entry_type wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output fosct_pkg::fosct_entry_type rd_data
);
   import fosct_pkg::*;

   fosct_entry_type mem_ff [DEPTH];
   fosct_entry_type rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/fosct_memo.sv
module fosct_memo #(
   parameter int KIND_COUNT = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fosct_pkg::DB_W-1:0]     key_db,
   input  logic [fosct_pkg::ROLE_W-1:0]   key_role,
   input  fosct_pkg::fosct_memo_cmd_type  cmd,
   output fosct_pkg::fosct_memo_stat_type stat
);
   import fosct_pkg::*;

   localparam int MW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;

   logic [DB_W-1:0]   memo_db_ff;
   logic [ROLE_W-1:0] memo_role_ff;
   logic              valid_ff [KIND_COUNT];
   logic [SLOT_W-1:0] slot_ff  [KIND_COUNT];
   logic              sel_ok;
   logic [MW-1:0]     sel_idx;

   // kinds past the memo size bypass it
   assign sel_ok  = int'(cmd.sel) < KIND_COUNT;
   assign sel_idx = MW'(cmd.sel);

   // key and valid bits; a new key drops every entry
   always_ff @(posedge clock) begin
      if (reset) begin
         memo_db_ff   <= '0;
         memo_role_ff <= '0;
         for (int k = 0; k < KIND_COUNT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (cmd.load_key) begin
         memo_db_ff   <= key_db;
         memo_role_ff <= key_role;
         for (int k = 0; k < KIND_COUNT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (cmd.update && sel_ok) begin
         valid_ff[sel_idx] <= 1'b1;
      end
   end

   // remembered slot per kind
   always_ff @(posedge clock) begin
      if (cmd.update && sel_ok) begin
         slot_ff[sel_idx] <= cmd.slot;
      end
   end

   // lookup
   always_comb begin
      stat.key_same = (memo_db_ff == key_db) && (memo_role_ff == key_role);
      stat.hit      = stat.key_same && sel_ok && valid_ff[sel_idx];
      stat.slot     = slot_ff[sel_idx];
   end

endmodule

### sv/find_or_create_slot_table_unit.sv
// Find-or-create slot table. Each request transfer carries a database id, a role id and
// a kind (negative kind is not part of the key); the response gives the slot index of
// the matching or newly claimed entry, or -1 with table_full when nothing is free.
// Database id 0 and slots_in_use 0 answer -1 without touching any state. A small
// per-kind memo, dropped whenever the id pair changes, answers a repeat request. Any
// other request scans the table memory one entry per cycle through its single
// registered read port, up to min(slots_in_use, TABLE_DEPTH) entries; requests are
// handled one at a time, and a finished response waits in the output register while
// the next request is taken. After reset the block clears every table entry and takes
// no request while it does so.
module find_or_create_slot_table_unit #(
   parameter int TABLE_DEPTH = 64,
   parameter int KIND_COUNT  = 4
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: slots_in_use
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   // request: database_id [31:0], role_id [63:32], entry_kind [66:64]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // response: slot_index [6:0], newly_claimed [7], table_full [8], first_full_report [9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata
);
   import fosct_pkg::*;

   localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW0   = $clog2(TABLE_DEPTH + 1);
   localparam int CNT_W = (CW0 > CFG_W) ? CW0 : CFG_W;

   fosct_state_type     state_ff, state_in;
   logic [CFG_W-1:0]    slots_ff;
   logic [DB_W-1:0]     db_ff, db_in;
   logic [ROLE_W-1:0]   role_ff, role_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [IW-1:0]       clr_ff, clr_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [IW-1:0]       last_ff, last_in;
   logic                free_vld_ff, free_vld_in;
   logic [IW-1:0]       free_ff, free_in;
   logic                full_rep_ff, full_rep_in;
   fosct_result_type    res_ff, res_in;
   fosct_result_type    out_ff, out_in;
   logic                rsp_vld_ff, rsp_vld_in;

   logic                mem_wr_en;
   logic [IW-1:0]       mem_wr_addr;
   fosct_entry_type     mem_wr_data;
   logic [IW-1:0]       mem_rd_addr;
   fosct_entry_type     mem_rd_data;
   fosct_memo_cmd_type  memo_cmd;
   fosct_memo_stat_type memo_stat;

   logic [CNT_W-1:0]    cfg_ext;
   logic [CNT_W-1:0]    count;
   logic                is_free;
   logic                is_match;
   logic [IW-1:0]       claim_idx;
   logic [SKIND_W-1:0]  kind_sel;

   fosct_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fosct_memo #(
      .KIND_COUNT (KIND_COUNT)
   ) u_memo (
      .clock    (clock),
      .reset    (reset),
      .key_db   (db_ff),
      .key_role (role_ff),
      .cmd      (memo_cmd),
      .stat     (memo_stat)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else if (csr_wr_en) begin
         slots_ff <= csr_wr_data;
      end
   end

   // searched entry count, saturated to the table size
   assign cfg_ext = CNT_W'(slots_ff);
   assign count   = (cfg_ext > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cfg_ext;

   // memo column and compare of the entry returned by the memory
   assign kind_sel  = kind_ff[KIND_W-1] ? '0 : kind_ff[SKIND_W-1:0];
   assign is_free   = (mem_rd_data.db == '0);
   assign is_match  = !is_free && (mem_rd_data.db == db_ff) && (mem_rd_data.role == role_ff)
                      && (kind_ff[KIND_W-1] || (mem_rd_data.kind == kind_ff[SKIND_W-1:0]));
   assign claim_idx = free_vld_ff ? free_ff : scan_ff;

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         full_rep_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         free_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         full_rep_ff <= full_rep_in;
         rsp_vld_ff  <= rsp_vld_in;
         free_vld_ff <= free_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      db_ff   <= db_in;
      role_ff <= role_in;
      kind_ff <= kind_in;
      scan_ff <= scan_in;
      last_ff <= last_in;
      free_ff <= free_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   // sequencer: clear pass, memo lookup, scan, claim, response hand-off
   always_comb begin
      state_in    = state_ff;
      db_in       = db_ff;
      role_in     = role_ff;
      kind_in     = kind_ff;
      clr_in      = clr_ff;
      scan_in     = scan_ff;
      last_in     = last_ff;
      free_vld_in = free_vld_ff;
      free_in     = free_ff;
      full_rep_in = full_rep_ff;
      res_in      = res_ff;
      out_in      = out_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_ff;
      mem_wr_data = '0;
      mem_rd_addr = scan_ff + IW'(1);
      memo_cmd    = '{load_key: 1'b0, update: 1'b0, sel: kind_sel,
                      slot: SLOT_W'(scan_ff)};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == IW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               db_in    = req_tdata[31:0];
               role_in  = req_tdata[63:32];
               kind_in  = req_tdata[66:64];
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            mem_rd_addr = '0;
            scan_in     = '0;
            free_vld_in = 1'b0;
            last_in     = IW'(count - CNT_W'(1));
            if (db_ff == '0 || slots_ff == '0) begin
               res_in   = '{slot: NO_SLOT, claimed: 1'b0, full: 1'b0, first: 1'b0};
               state_in = ST_DONE;
            end else if (!memo_stat.key_same) begin
               memo_cmd.load_key = 1'b1;
               state_in          = ST_SCAN;
            end else if (memo_stat.hit) begin
               res_in   = '{slot: memo_stat.slot, claimed: 1'b0, full: 1'b0, first: 1'b0};
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + IW'(1);
            if (is_free && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_in     = scan_ff;
            end
            if (is_match) begin
               memo_cmd.update = 1'b1;
               res_in   = '{slot: SLOT_W'(scan_ff), claimed: 1'b0, full: 1'b0, first: 1'b0};
               state_in = ST_DONE;
            end else if (scan_ff == last_ff) begin
               if (free_vld_ff || is_free) begin
                  // claim the first free entry
                  mem_wr_en        = 1'b1;
                  mem_wr_addr      = claim_idx;
                  mem_wr_data.db   = db_ff;
                  mem_wr_data.role = role_ff;
                  mem_wr_data.kind = kind_sel;
                  memo_cmd.update  = 1'b1;
                  memo_cmd.slot    = SLOT_W'(claim_idx);
                  res_in = '{slot: SLOT_W'(claim_idx), claimed: 1'b1, full: 1'b0,
                             first: 1'b0};
               end else begin
                  full_rep_in = 1'b1;
                  res_in = '{slot: NO_SLOT, claimed: 1'b0, full: 1'b1,
                             first: !full_rep_ff};
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               out_in     = res_ff;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'b0, out_ff.first, out_ff.full, out_ff.claimed, out_ff.slot};

`ifndef ASSERT_OFF
   // a response never both claims and reports full
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_ff.claimed && out_ff.full))
      else $error("claimed and full together");

   // first full report only comes with a full event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.first) |-> (out_ff.full && out_ff.slot == NO_SLOT))
      else $error("first full report without full");

   // the full report flag only clears at reset
   assert property (@(posedge clock) disable iff (reset)
      full_rep_ff |=> full_rep_ff)
      else $error("full report flag dropped");

   // a claim never writes the reserved database id
   assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && state_ff != ST_CLEAR) |-> (mem_wr_data.db != '0))
      else $error("claim with invalid database id");

   // the memo is only updated at the end of a scan
   assert property (@(posedge clock) disable iff (reset)
      memo_cmd.update |-> (state_ff == ST_SCAN && state_in == ST_DONE))
      else $error("memo update outside scan end");
`endif

endmodule
